FILE: src/cfdd_pkg.sv
// Shared types, codes and the byte-wide CRC32 update for the frame deframer.
// Depends on nothing; every other file of the block imports it.
package cfdd_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_END_BYTE   = 2'd1;
    localparam logic [1:0] REG_MAX_LEN    = 2'd2;

    localparam logic [7:0]  START_BYTE_RST = 8'hAA;
    localparam logic [7:0]  END_BYTE_RST   = 8'h55;
    localparam logic [15:0] MAX_LEN_RST    = 16'd1024;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd2;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_type;
        logic [15:0] frame_len;
        logic [1:0]  status;
        logic [31:0] crc_value;
    } result_t;

    // Reflected CRC32 advanced by one byte, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [31:0] c;
        begin
            c = crc_in ^ {24'h0, data_in};
            for (int k = 0; k < 8; k++) begin
                c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'h0);
            end
            return c;
        end
    endfunction

endpackage

FILE: src/cfdd_parser.sv
// Front end of the deframer: configuration registers, frame parser and CRC.
// Depends on cfdd_pkg; pushes finished results into cfdd_queue.
module cfdd_parser
    import cfdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_buf_end,
    input  logic        q_full,
    output logic        q_push,
    output result_t     q_data
);

    typedef enum logic [2:0] {
        PH_START, PH_LEN_LO, PH_LEN_HI, PH_TYPE,
        PH_PAYLOAD, PH_CRC, PH_END, PH_DRAIN
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rxcrc_reg, rxcrc_next;

    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [15:0] max_len_reg;

    logic        accept;
    logic        st_hit;
    logic [1:0]  st_code;
    logic        emit;
    logic [16:0] count_inc;
    logic [31:0] crc_upd;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign crc_upd   = crc32_byte(crc_reg, s_rx_byte);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        crc_next   = crc_reg;
        rxcrc_next = rxcrc_reg;
        st_hit     = 1'b0;
        st_code    = STATUS_MALFORMED;
        emit       = 1'b0;
        unique case (phase_reg)
            PH_START: begin
                // Every start-byte step opens a fresh frame.
                count_next = '0;
                len_next   = '0;
                type_next  = '0;
                crc_next   = CRC_INIT;
                rxcrc_next = '0;
                if (s_rx_byte == start_byte_reg) begin
                    phase_next = PH_LEN_LO;
                end else begin
                    st_hit = 1'b1;
                end
            end
            PH_LEN_LO: begin
                len_next   = {8'h00, s_rx_byte};
                crc_next   = crc_upd;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next = {s_rx_byte, len_reg[7:0]};
                crc_next = crc_upd;
                if (len_next > max_len_reg) begin
                    st_hit = 1'b1;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = s_rx_byte;
                crc_next   = crc_upd;
                count_next = '0;
                phase_next = (len_reg != 16'd0) ? PH_PAYLOAD : PH_CRC;
            end
            PH_PAYLOAD: begin
                crc_next = crc_upd;
                emit     = 1'b1;
                if (count_inc >= {1'b0, len_reg}) begin
                    count_next = '0;
                    phase_next = PH_CRC;
                end else begin
                    count_next = count_inc[15:0];
                end
            end
            PH_CRC: begin
                rxcrc_next = rxcrc_reg | ({24'h0, s_rx_byte} << {count_reg[1:0], 3'b000});
                if (count_reg[1:0] == 2'd3) begin
                    count_next = '0;
                    phase_next = PH_END;
                end else begin
                    count_next = count_inc[15:0];
                end
            end
            PH_END: begin
                st_hit = 1'b1;
                if (s_rx_byte != end_byte_reg) begin
                    st_code = STATUS_MALFORMED;
                end else if (~crc_reg != rxcrc_reg) begin
                    st_code = STATUS_CRC_ERR;
                end else begin
                    st_code = STATUS_OK;
                end
            end
            PH_DRAIN: begin
            end
            default: begin
            end
        endcase

        // A buffer that ends inside a frame is reported as malformed.
        if (st_hit) begin
            phase_next = s_buf_end ? PH_START : PH_DRAIN;
        end else if (s_buf_end) begin
            if (phase_reg != PH_DRAIN) begin
                st_hit  = 1'b1;
                st_code = STATUS_MALFORMED;
            end
            phase_next = PH_START;
        end
    end

    always_comb begin
        q_data.frame_type = type_next;
        q_data.frame_len  = len_next;
        if (st_hit) begin
            q_data.out_kind      = KIND_STATUS;
            q_data.payload_byte  = '0;
            q_data.payload_index = '0;
            q_data.status        = st_code;
            q_data.crc_value     = rxcrc_next;
        end else begin
            q_data.out_kind      = KIND_PAYLOAD;
            q_data.payload_byte  = s_rx_byte;
            q_data.payload_index = count_reg;
            q_data.status        = STATUS_OK;
            q_data.crc_value     = '0;
        end
    end

    assign q_push = accept && (st_hit || emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            count_reg      <= '0;
            len_reg        <= '0;
            type_reg       <= '0;
            crc_reg        <= CRC_INIT;
            rxcrc_reg      <= '0;
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg   <= END_BYTE_RST;
            max_len_reg    <= MAX_LEN_RST;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                len_reg   <= len_next;
                type_reg  <= type_next;
                crc_reg   <= crc_next;
                rxcrc_reg <= rxcrc_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_START_BYTE: start_byte_reg <= cfg_wr_data[7:0];
                    REG_END_BYTE:   end_byte_reg   <= cfg_wr_data[7:0];
                    REG_MAX_LEN:    max_len_reg    <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: src/cfdd_queue.sv
// Small result queue that decouples the parser from the output stage.
// Depends on cfdd_pkg for the result type.
module cfdd_queue
    import cfdd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    pop_valid,
    output result_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/cfdd_out_stage.sv
// Back end of the deframer: registered result stage that drives the m_ channel.
// Depends on cfdd_pkg; pulls results out of cfdd_queue.
module cfdd_out_stage
    import cfdd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  result_t q_data,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    valid_reg;
    result_t data_reg;

    assign q_pop   = q_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

FILE: src/crc32_frame_deframer_unit.sv
// Top level of the CRC32-checked frame deframer.
// Depends on cfdd_pkg, cfdd_parser, cfdd_queue and cfdd_out_stage.
//
// Usage: the s_ channel carries one buffer byte per transaction, with s_buf_end
// high on the last byte of the buffer. The m_ channel carries one result per
// transaction: a payload byte (m_out_kind 0) or the frame status (m_out_kind 1).
// Each buffer yields exactly one status transaction; payload bytes come first,
// and the consumer discards them when the status is nonzero.
// The queue entry is written at the edge that accepts the byte, and the output
// register loads from the queue when it is empty or m_ready is high; the result
// is then valid on m_.
// Throughput: one byte per cycle unless the queue is full; the CRC is byte-wide.
// The cfg_ port writes start_byte, end_byte and max_payload_len; the user must
// write it only while no transaction is in flight; the block does not enforce it.
// Reset (aresetn low, synchronous) restores the register defaults, empties the
// queue and returns the parser to waiting for a start byte.
// When the receiver stalls, results collect in the queue; s_ready drops only
// once the queue is full, and resumes as soon as one entry drains.
module crc32_frame_deframer_unit
    import cfdd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    // Byte input channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_buf_end,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_kind,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_index,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_frame_len,
    output logic [1:0]  m_status,
    output logic [31:0] m_crc_value
);

    logic    q_full, q_push, q_pop, q_valid;
    result_t push_data, pop_data, out_data;

    // The front end parses every accepted byte in the cycle it arrives.
    cfdd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .s_buf_end   (s_buf_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    // The queue absorbs results while the receiver stalls.
    cfdd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_data)
    );

    // The back end presents results from a register.
    cfdd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (out_data)
    );

    assign m_out_kind      = out_data.out_kind;
    assign m_payload_byte  = out_data.payload_byte;
    assign m_payload_index = out_data.payload_index;
    assign m_frame_type    = out_data.frame_type;
    assign m_frame_len     = out_data.frame_len;
    assign m_status        = out_data.status;
    assign m_crc_value     = out_data.crc_value;

    // A full queue means the output register is occupied as well.
    a_full_implies_out_valid: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid
    ) else $error("input stalled while the output stage is empty");

    // Payload results never carry a status code or a CRC field.
    a_payload_fields_clear: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind == KIND_PAYLOAD)) |->
            ((m_status == STATUS_OK) && (m_crc_value == 32'h0))
    ) else $error("payload result carries status or CRC bits");

    // Status results never carry payload data, and never an undefined code.
    a_status_fields: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind == KIND_STATUS)) |->
            ((m_payload_byte == 8'h0) && (m_payload_index == 16'h0) &&
             (m_status <= STATUS_CRC_ERR))
    ) else $error("status result is malformed");

endmodule
